// ----- design/dht_pkg.sv -----
// ----------------------------------------------------------------------------
// dht_pkg
// Types and constants shared by the double hashing table engine.
// ----------------------------------------------------------------------------
`default_nettype none
package dht_pkg;

  localparam int unsigned CFG_W = 16;
  localparam logic CFG_TABLE_SIZE = 1'b0;
  localparam logic CFG_STEP_PRIME = 1'b1;
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;
  localparam logic [12:0] TABLE_SIZE_RST = 13'd3967;
  localparam logic [15:0] STEP_PRIME_RST = 16'd3779;

  typedef struct packed {
    logic        op;
    logic [31:0] key_hash;
    logic [63:0] key;
  } dht_in_t;

  typedef struct packed {
    logic [12:0] extra_probes;
    logic        success;
    logic [11:0] slot;
    logic [31:0] insert_probe_total;
    logic [31:0] lookup_probe_total;
  } dht_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_STEP, ST_MOD, ST_READ, ST_CHECK, ST_DONE
  } dht_state_t;

endpackage
`default_nettype wire

// ----- design/double_hash_table_engine_top.sv -----
// ----------------------------------------------------------------------------
// double_hash_table_engine_top
// Double hashing open-addressing hash table, insert and lookup.
// ----------------------------------------------------------------------------
// Input words (op, key_hash, key) enter on in_valid/in_stall; one result word
// per request leaves on out_valid/out_stall. The user must write registers
// through cfg_we/cfg_index/cfg_data only while idle; the block does not
// enforce this. A request runs one remainder for the step, then for each
// probed slot one remainder by table size plus a memory read and compare.
// The single bit-serial remainder unit serves both kinds of remainder. The
// block takes a new word once the previous result is loaded into the output
// register, so a stalled receiver holds only one result while the next
// request runs; a second result waits until the first is taken.
// After reset a clearing pass empties the occupancy store with in_stall high;
// probe totals and registers reset at once. Key store contents are unset at
// reset.
// ----------------------------------------------------------------------------
`default_nettype none
module double_hash_table_engine_top #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned KEY_BITS    = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire dht_pkg::dht_in_t            in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output dht_pkg::dht_out_t                out_data,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [dht_pkg::CFG_W-1:0]   cfg_data
);
  import dht_pkg::*;
  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic [12:0] table_size;
  logic [15:0] step_prime;
  logic occ_mem [TABLE_DEPTH];
  logic [KEY_BITS-1:0] mem [TABLE_DEPTH];
  logic [KEY_BITS-1:0] rd_key;
  logic rd_occ;
  dht_state_t state, state_next;
  logic op;
  logic [31:0] h, step, acc;
  logic [KEY_BITS-1:0] key;
  logic [12:0] cnt;
  logic [AW-1:0] pos;
  logic [AW-1:0] clr_addr;
  logic [31:0] isum, lsum;
  logic [16:0] size_eff;
  logic [15:0] prime_eff;
  logic mstart, mdone;
  logic [31:0] mdvd;
  logic [15:0] mdiv, mrem;
  logic hit, give_up, gdone;
  logic [32:0] sum_i, sum_l;
  logic [15:0] mod_res;
  dht_out_t res;

  always_comb begin
    size_eff = {4'd0, table_size};
    if (table_size == 13'd0) size_eff = 17'd1;
    if ({4'd0, table_size} > 17'(TABLE_DEPTH)) size_eff = 17'(TABLE_DEPTH);
    prime_eff = (step_prime == 16'd0) ? 16'd1 : step_prime;
  end

  assign mdiv = (state == ST_STEP) ? prime_eff : size_eff[15:0];
  assign mdvd = (state == ST_IDLE)  ? in_data.key_hash :
                (state == ST_STEP)  ? h :
                (state == ST_CHECK) ? acc + step : acc;

  // a table size of 65536 overflows the 16-bit divisor: treat full depth as mask case
  assign mod_res = (size_eff == 17'h10000) ? acc[15:0] : mrem;

  dht_modu u_mod (
    .clk(clk), .rst(rst), .start(mstart), .dividend(mdvd), .divisor(mdiv),
    .done(mdone), .remainder(mrem)
  );

  assign hit = (op == OP_INSERT) ? !rd_occ : (rd_occ && rd_key == key);
  assign give_up = ({4'd0, cnt} + 17'd1 >= size_eff);
  assign in_stall = (state != ST_IDLE);
  assign gdone = (state == ST_CHECK) && (hit || give_up);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_addr == AW'(TABLE_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid && !in_stall) state_next = ST_STEP;
      ST_STEP:  if (mdone) state_next = ST_MOD;
      ST_MOD:   if (mdone || size_eff == 17'h10000) state_next = ST_READ;
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: state_next = (hit || give_up) ? ST_DONE : ST_MOD;
      ST_DONE:  if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mstart = 1'b0;
    unique case (state)
      ST_IDLE:  mstart = in_valid && !in_stall;
      ST_STEP:  mstart = mdone;
      ST_CHECK: mstart = !(hit || give_up);
      default:  mstart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      occ_mem[clr_addr] <= 1'b0;
    end else if (state == ST_CHECK && op == OP_INSERT && !rd_occ) begin
      occ_mem[pos] <= 1'b1;
      mem[pos] <= key;
    end
    if (state == ST_READ) begin
      rd_key <= mem[pos];
      rd_occ <= occ_mem[pos];
    end
  end

  assign sum_i = {1'b0, isum} + 33'(cnt + 13'(!hit));
  assign sum_l = {1'b0, lsum} + 33'(cnt + 13'(!hit));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      isum <= '0;
      lsum <= '0;
      out_valid <= 1'b0;
      table_size <= TABLE_SIZE_RST;
      step_prime <= STEP_PRIME_RST;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == CFG_TABLE_SIZE) table_size <= cfg_data[12:0];
        else step_prime <= cfg_data;
      end
      if (state == ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      if (state == ST_IDLE && in_valid && !in_stall) begin
        op <= in_data.op;
        h <= in_data.key_hash;
        key <= in_data.key[KEY_BITS-1:0];
        cnt <= '0;
      end
      if (state == ST_STEP && mdone) begin
        step <= {16'd0, prime_eff - mrem};
        acc <= h;
      end
      if (state == ST_MOD && (mdone || size_eff == 17'h10000)) begin
        pos <= mod_res[AW-1:0];
      end
      if (state == ST_CHECK) begin
        if (!gdone) begin
          cnt <= cnt + 13'd1;
          acc <= acc + step;
        end else begin
          res.extra_probes <= hit ? cnt : cnt + 13'd1;
          res.success <= hit;
          res.slot <= hit ? 12'(pos) : 12'd0;
          if (op == OP_INSERT) begin
            isum <= sum_i[32] ? 32'hFFFF_FFFF : sum_i[31:0];
            res.insert_probe_total <= sum_i[32] ? 32'hFFFF_FFFF : sum_i[31:0];
            res.lookup_probe_total <= lsum;
          end else begin
            lsum <= sum_l[32] ? 32'hFFFF_FFFF : sum_l[31:0];
            res.lookup_probe_total <= sum_l[32] ? 32'hFFFF_FFFF : sum_l[31:0];
            res.insert_probe_total <= isum;
          end
        end
      end
      if (state == ST_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
        out_data <= res;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall) else $error("accepted while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    state == ST_CHECK |-> {4'd0, cnt} < size_eff) else $error("probe overrun");
`endif
endmodule
`default_nettype wire

// ----- design/dht_modu.sv -----
// ----------------------------------------------------------------------------
// dht_modu
// Shared restoring remainder unit: 32-bit dividend, 16-bit divisor, one bit
// a cycle; done rises when the remainder is complete.
// ----------------------------------------------------------------------------
`default_nettype none
module dht_modu (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [15:0]      remainder
);
  logic [31:0] dvd;
  logic [16:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [16:0] trial;

  assign trial = {rem[15:0], dvd[31]};
  assign remainder = rem[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        dvd <= {dvd[30:0], 1'b0};
        rem <= (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_no_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("remainder done without work");
  a_rem_lt: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < {1'b0, divisor}) else $error("remainder not reduced");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !$past(start) || $past(rst)) else $error("start lost");
`endif
endmodule
`default_nettype wire
